[hw/rtl/gtid_pkg.sv]
// gtid_pkg: shared types and constants of the GTID list parser.
// Character codes, token classes, result status codes and queue handshake structs.
// No dependencies.
package gtid_pkg;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [1:0] DASHES_NEEDED = 2'd2;
  localparam logic [1:0] DASH_SAT      = 2'd3;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_DASH  = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_COMMA = 3'd4,
    CLS_OTHER = 3'd5
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DASHES    = 3'd1,
    ST_BAD_SEG   = 3'd2,
    ST_OVF_DOM   = 3'd3,
    ST_OVF_SRV   = 3'd4,
    ST_OVF_SEQ   = 3'd5,
    ST_END_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       eot;
  } tok_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

[hw/rtl/gtid_if.sv]
// gtid_in_if / gtid_out_if: valid/ready channels of the GTID list parser.
// Input carries one text byte per beat, output one parse result per beat.
// No dependencies.
interface gtid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       end_of_text;

  modport source(output valid, output char_code, output char_present,
                 output end_of_text, input ready);
  modport sink(input valid, input char_code, input char_present,
               input end_of_text, output ready);
endinterface

interface gtid_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] domain_value;
  logic [31:0] server_value;
  logic [63:0] sequence_value;
  logic        last_of_set;

  modport source(output valid, output status, output domain_value,
                 output server_value, output sequence_value,
                 output last_of_set, input ready);
  modport sink(input valid, input status, input domain_value,
               input server_value, input sequence_value,
               input last_of_set, output ready);
endinterface

[hw/rtl/gtid_list_parser.sv]
// gtid_list_parser: streaming parser of comma-separated domain-server-sequence lists.
// Results are registered: a closing byte passes the queue, then the result register.
// Throughput: one input beat and one retired token per cycle while neither side stalls.
// The token queue (QDEPTH entries) lets input and output stall independently.
// Reset: synchronous, active low; clears queue, parser state and output valid.
// Depends on gtid_pkg, gtid_if, gtid_front, gtid_queue, gtid_back.
module gtid_list_parser
  import gtid_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  gtid_in_if.sink    in_if,
  gtid_out_if.source out_if
);

  q_stat_t q_stat;
  logic    push, pop;
  tok_t    push_tok, q_tok;

  gtid_front u_front (
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_tok (push_tok)
  );

  gtid_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .q_tok    (q_tok),
    .q_stat   (q_stat)
  );

  gtid_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_tok  (q_tok),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("token popped from empty queue");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_OK) |-> out_if.last_of_set)
    else $error("error result without last_of_set");

  a_error_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_OK) |->
      (out_if.domain_value == '0 && out_if.server_value == '0 &&
       out_if.sequence_value == '0))
    else $error("non-ok result carries values");

  a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");

endmodule

[hw/rtl/gtid_front.sv]
// gtid_front: accepts input beats and classifies each byte into a token.
// Depends on gtid_pkg and gtid_in_if; feeds gtid_queue.
module gtid_front
  import gtid_pkg::*;
(
  gtid_in_if.sink in_if,
  input  q_stat_t q_stat,
  output logic    push,
  output tok_t    push_tok
);

  logic [7:0] c;

  assign c            = in_if.char_code;
  assign in_if.ready  = !q_stat.full;
  assign push         = in_if.valid && !q_stat.full;

  always_comb begin
    push_tok.digit = c[3:0];
    push_tok.eot   = in_if.end_of_text;
    if (!in_if.char_present) begin
      push_tok.cls = CLS_NONE;
    end else if (c == CH_COMMA) begin
      push_tok.cls = CLS_COMMA;
    end else if (c == CH_DASH) begin
      push_tok.cls = CLS_DASH;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      push_tok.cls = CLS_DIGIT;
    end else if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
      push_tok.cls = CLS_SPACE;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

endmodule

[hw/rtl/gtid_queue.sv]
// gtid_queue: small token FIFO between front and back of the GTID parser.
// Depends on gtid_pkg.
module gtid_queue
  import gtid_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  tok_t    push_tok,
  input  logic    pop,
  output tok_t    q_tok,
  output q_stat_t q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign q_tok        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/gtid_back.sv]
// gtid_back: entry state machine, digit accumulation and result register.
// Depends on gtid_pkg and gtid_out_if; drains tokens from gtid_queue.
module gtid_back
  import gtid_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  tok_t    q_tok,
  input  q_stat_t q_stat,
  output logic    pop,
  gtid_out_if.source out_if
);

  typedef struct packed {
    logic [31:0] dom;
    logic [31:0] srv;
    logic [63:0] seq;
    logic [1:0]  dash;
    logic        has_digit;
    logic        bad;
    logic [2:0]  ovf;
    logic        started;
    logic        space_pend;
    logic        draining;
  } pst_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] dom;
    logic [31:0] srv;
    logic [63:0] seq;
  } res_t;

  function automatic pst_t take_char(pst_t s, tok_t t);
    pst_t        n;
    logic [31:0] a;
    logic [35:0] v32;
    logic [67:0] v64;
    n   = s;
    a   = (s.dash == 2'd0) ? s.dom : s.srv;
    v32 = ({4'b0, a} << 3) + ({4'b0, a} << 1) + 36'(t.digit);
    v64 = ({4'b0, s.seq} << 3) + ({4'b0, s.seq} << 1) + 68'(t.digit);
    unique case (t.cls)
      CLS_SPACE: begin
        if (s.started) n.space_pend = 1'b1;
      end
      CLS_DASH, CLS_DIGIT, CLS_OTHER: begin
        n.started = 1'b1;
        if (s.space_pend) begin
          n.bad        = 1'b1;
          n.space_pend = 1'b0;
        end
        unique case (t.cls)
          CLS_DASH: begin
            if (!s.has_digit) n.bad = 1'b1;
            if (s.dash != DASH_SAT) n.dash = s.dash + 2'd1;
            n.has_digit = 1'b0;
          end
          CLS_DIGIT: begin
            n.has_digit = 1'b1;
            unique case (s.dash)
              2'd0: begin
                if (v32[35:32] != '0) n.ovf[0] = 1'b1;
                else n.dom = v32[31:0];
              end
              2'd1: begin
                if (v32[35:32] != '0) n.ovf[1] = 1'b1;
                else n.srv = v32[31:0];
              end
              2'd2: begin
                if (v64[67:64] != '0) n.ovf[2] = 1'b1;
                else n.seq = v64[63:0];
              end
              default: ;
            endcase
          end
          default: n.bad = 1'b1;
        endcase
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic res_t close_entry(pst_t s);
    res_t r;
    logic bad;
    bad = s.bad || !s.has_digit;
    r   = '0;
    priority if (!s.started)             r.st = ST_END_EMPTY;
    else if (s.dash != DASHES_NEEDED)    r.st = ST_DASHES;
    else if (bad)                        r.st = ST_BAD_SEG;
    else if (s.ovf[0])                   r.st = ST_OVF_DOM;
    else if (s.ovf[1])                   r.st = ST_OVF_SRV;
    else if (s.ovf[2])                   r.st = ST_OVF_SEQ;
    else                                 r.st = ST_OK;
    if (r.st == ST_OK) begin
      r.dom = s.dom;
      r.srv = s.srv;
      r.seq = s.seq;
    end
    return r;
  endfunction

  pst_t  s_r, s_nxt, s_upd, s_clr;
  res_t  res;
  logic  is_comma, emit, last;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;
  logic  out_last_r;

  assign pop      = q_stat.valid && (!out_valid_r || out_if.ready);
  assign is_comma = (q_tok.cls == CLS_COMMA);
  assign s_upd    = take_char(s_r, q_tok);
  assign res      = close_entry(s_upd);
  assign emit     = !s_r.draining && ((is_comma && s_r.started) || q_tok.eot);
  assign last     = q_tok.eot || (res.st != ST_OK);

  always_comb begin
    s_clr          = '0;
    s_clr.draining = s_r.draining;
    priority if (s_r.draining) begin
      s_nxt = q_tok.eot ? '0 : s_r;
    end else if (emit && last) begin
      s_nxt          = '0;
      s_nxt.draining = (res.st != ST_OK) && !q_tok.eot;
    end else if (is_comma) begin
      s_nxt = s_clr;
    end else begin
      s_nxt = s_upd;
    end
  end

  assign out_valid_nxt = (pop && emit) ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) s_r <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_res_r  <= res;
      out_last_r <= last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_res_r.st;
  assign out_if.domain_value   = out_res_r.dom;
  assign out_if.server_value   = out_res_r.srv;
  assign out_if.sequence_value = out_res_r.seq;
  assign out_if.last_of_set    = out_last_r;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for gtid_list_parser; streams random and directed list text,
// predicts each parse result and compares every result beat field by field.
// Depends on gtid_pkg, gtid_if (gtid_in_if, gtid_out_if) and gtid_list_parser.
module tb;
  import gtid_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       present;
    logic       eot;
  } chr_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] dom;
    logic [31:0] srv;
    logic [63:0] seq;
    logic        last;
  } gtid_res_t;

  logic clk;
  logic rst_n;

  gtid_in_if  char_ch();
  gtid_out_if res_ch();

  gtid_list_parser i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (char_ch),
    .out_if(res_ch)
  );

  chr_beat_t  text_beats[$];
  gtid_res_t  gtid_results_due[$];
  logic [7:0] list_text[$];
  chr_beat_t  on_wire;
  gtid_res_t  got_due;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int stim_items;
  int list_count;
  int beats_sent;
  int status_tally[7];

  // predictor state
  logic [31:0] dom_sum;
  logic [31:0] srv_sum;
  logic [63:0] seq_sum;
  logic [1:0]  dash_cnt;
  logic        seg_digit;
  logic        seg_bad;
  logic [2:0]  ovf;
  logic        in_entry;
  logic        ws_after;
  logic        skip_rest;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_entry();
    dom_sum   = '0;
    srv_sum   = '0;
    seq_sum   = '0;
    dash_cnt  = '0;
    seg_digit = 1'b0;
    seg_bad   = 1'b0;
    ovf       = '0;
    in_entry  = 1'b0;
    ws_after  = 1'b0;
  endtask

  task automatic restart_list();
    clear_entry();
    skip_rest = 1'b0;
  endtask

  task automatic add_digit(logic [3:0] d);
    logic [35:0] w32;
    logic [67:0] w64;
    seg_digit = 1'b1;
    case (dash_cnt)
      2'd0: begin
        w32 = dom_sum * 36'd10 + d;
        if (w32[35:32] != 0) ovf[0] = 1'b1;
        else dom_sum = w32[31:0];
      end
      2'd1: begin
        w32 = srv_sum * 36'd10 + d;
        if (w32[35:32] != 0) ovf[1] = 1'b1;
        else srv_sum = w32[31:0];
      end
      DASHES_NEEDED: begin
        w64 = seq_sum * 68'd10 + d;
        if (w64[67:64] != 0) ovf[2] = 1'b1;
        else seq_sum = w64[63:0];
      end
      default: ;
    endcase
  endtask

  task automatic take_char(logic [7:0] c);
    logic [7:0] d;
    if (is_blank(c)) begin
      if (in_entry) ws_after = 1'b1;
    end else begin
      in_entry = 1'b1;
      if (ws_after) begin
        seg_bad  = 1'b1;
        ws_after = 1'b0;
      end
      if (c == CH_DASH) begin
        if (!seg_digit) seg_bad = 1'b1;
        if (dash_cnt != DASH_SAT) dash_cnt++;
        seg_digit = 1'b0;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        add_digit(d[3:0]);
      end else begin
        seg_bad = 1'b1;
      end
    end
  endtask

  function automatic gtid_res_t close_entry();
    gtid_res_t r;
    r = '0;
    if (!seg_digit) seg_bad = 1'b1;
    if (dash_cnt != DASHES_NEEDED) r.status = ST_DASHES;
    else if (seg_bad)              r.status = ST_BAD_SEG;
    else if (ovf[0])               r.status = ST_OVF_DOM;
    else if (ovf[1])               r.status = ST_OVF_SRV;
    else if (ovf[2])               r.status = ST_OVF_SEQ;
    else begin
      r.status = ST_OK;
      r.dom    = dom_sum;
      r.srv    = srv_sum;
      r.seq    = seq_sum;
    end
    return r;
  endfunction

  task automatic parse_beat(chr_beat_t b);
    gtid_res_t r;
    bit closed;
    closed = 1'b0;
    if (skip_rest) begin
      if (b.eot) restart_list();
    end else begin
      if (b.present && b.code == CH_COMMA) begin
        if (in_entry) begin
          r = close_entry();
          closed = 1'b1;
          if (r.status != ST_OK || b.eot) begin
            r.last = 1'b1;
            restart_list();
            if (r.status != ST_OK && !b.eot) skip_rest = 1'b1;
          end else begin
            clear_entry();
          end
          gtid_results_due.insert(gtid_results_due.size(), r);
        end else begin
          clear_entry();
        end
      end else if (b.present) begin
        take_char(b.code);
      end
      if (!closed && b.eot) begin
        if (in_entry) begin
          r = close_entry();
        end else begin
          r = '0;
          r.status = ST_END_EMPTY;
        end
        r.last = 1'b1;
        restart_list();
        gtid_results_due.insert(gtid_results_due.size(), r);
      end
    end
  endtask

  // stimulus helpers
  task automatic queue_beat(logic [7:0] code, logic present, logic eot);
    chr_beat_t b;
    b.code    = code;
    b.present = present;
    b.eot     = eot;
    text_beats.insert(text_beats.size(), b);
    if (present || eot) stim_items++;
  endtask

  task automatic queue_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++)
      queue_beat(s[i], 1'b1, eot_last && i == s.len() - 1);
  endtask

  task automatic add_byte(logic [7:0] c);
    list_text.insert(list_text.size(), c);
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SP : CH_TAB + k[7:0];
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || c == CH_DASH || c == CH_COMMA || c == 8'h00 ||
           (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  function automatic logic [63:0] pick_val(bit wide);
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
      2:       return 64'($urandom_range(0, 9));
      3:       return 64'($urandom_range(0, 99999));
      4:       return (wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF) -
                      64'($urandom_range(0, 9));
      default: return wide ? {$urandom, $urandom} : {32'd0, $urandom};
    endcase
  endfunction

  function automatic string num_text(logic [63:0] v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s = {"0", s};
    return s;
  endfunction

  function automatic string over_text(bit wide);
    logic [63:0] v;
    string s;
    if (wide) begin
      if ($urandom_range(0, 1)) begin
        s = $sformatf("1844674407370955161%0d", $urandom_range(6, 9));
      end else begin
        s = $sformatf("%0d", $urandom_range(1, 9));
        repeat ($urandom_range(20, 22)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
    end else begin
      v = $urandom_range(0, 1) ? 64'h1_0000_0000 + 64'($urandom_range(0, 9))
                               : {$urandom_range(1, 32'hFFFF), $urandom};
      s = $sformatf("%0d", v);
    end
    return s;
  endfunction

  task automatic add_entry();
    string seg[6];
    int kind, nseg, bad_at, cut;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 6; i++) seg[i] = num_text(pick_val(i == 2));
    if (kind >= 80 && kind < 95) begin
      seg[(kind - 80) / 5] = over_text((kind - 80) / 5 == 2);
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(0, 2);
        seg[cut] = over_text(cut == 2);
      end
    end
    if (kind >= 65 && kind < 70) seg[$urandom_range(0, 2)] = "";
    nseg = 3;
    if (kind >= 55 && kind < 60) begin
      nseg = 0;
    end else if (kind >= 60 && kind < 65) begin
      nseg = $urandom_range(1, 5);
      if (nseg >= 3) nseg++;
    end
    bad_at = (kind >= 70 && kind < 80) ? $urandom_range(0, nseg - 1) : -1;
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_byte(pick_blank());
    if (kind >= 95) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < nseg; i++) begin
        if (i > 0) add_byte(CH_DASH);
        cut = $urandom_range(0, seg[i].len());
        for (int j = 0; j <= seg[i].len(); j++) begin
          if (i == bad_at && j == cut) begin
            if (kind < 75) add_byte(pick_junk());
            else repeat ($urandom_range(1, 2)) add_byte(pick_blank());
          end
          if (j < seg[i].len()) add_byte(seg[i][j]);
        end
      end
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_byte(pick_blank());
  endtask

  task automatic add_list(int n_entries);
    int tail;
    bit eot_on_char;
    list_text.delete();
    for (int i = 0; i < n_entries; i++) begin
      if (i > 0) add_byte(CH_COMMA);
      add_entry();
    end
    tail = $urandom_range(0, 9);
    if (tail >= 5 && tail < 7) add_byte(CH_COMMA);
    eot_on_char = tail < 7 && list_text.size() != 0;
    foreach (list_text[i]) begin
      if ($urandom_range(0, 99) < 3) queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_beat(list_text[i], 1'b1, eot_on_char && i == list_text.size() - 1);
    end
    if (!eot_on_char) queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    list_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (text_beats.size() != 0 || char_ch.valid || gtid_results_due.size() != 0);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      char_ch.valid        <= 1'b0;
      char_ch.char_code    <= '0;
      char_ch.char_present <= 1'b0;
      char_ch.end_of_text  <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        parse_beat(on_wire);
        beats_sent++;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (text_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire = text_beats.pop_front();
          char_ch.valid        <= 1'b1;
          char_ch.char_code    <= on_wire.code;
          char_ch.char_present <= on_wire.present;
          char_ch.end_of_text  <= on_wire.eot;
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    res_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (gtid_results_due.size() == 0) begin
        $error("result beat with nothing pending: status %0d", res_ch.status);
        mismatch_count++;
      end else begin
        got_due = gtid_results_due.pop_front();
        status_tally[got_due.status]++;
        check_field("status", 64'(got_due.status), 64'(res_ch.status));
        check_field("domain_value", 64'(got_due.dom), 64'(res_ch.domain_value));
        check_field("server_value", 64'(got_due.srv), 64'(res_ch.server_value));
        check_field("sequence_value", got_due.seq, res_ch.sequence_value);
        check_field("last_of_set", 64'(got_due.last), 64'(res_ch.last_of_set));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    restart_list();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bare end, idle beat, zero triple, comma on last beat,
    // lone comma at end, error then draining, NUL byte
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'hFF, 1'b0, 1'b0);
    queue_text("0-0-0", 1'b1);
    queue_text("1-2-3,", 1'b1);
    queue_beat(CH_COMMA, 1'b1, 1'b1);
    queue_text("-,", 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b1);
    stim_items = 0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 19 : 0;
      while (stim_items < (ph + 1) * 420) add_list($urandom_range(0, 8));
      wait_drained();
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d text beats in %0d random lists plus directed cases.", beats_sent,
             list_count);
    $display("Results: ok %0d, dashes %0d, bad segment %0d, overflow %0d/%0d/%0d, end %0d",
             status_tally[ST_OK], status_tally[ST_DASHES], status_tally[ST_BAD_SEG],
             status_tally[ST_OVF_DOM], status_tally[ST_OVF_SRV], status_tally[ST_OVF_SEQ],
             status_tally[ST_END_EMPTY]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
